// ----- rtl/core/mpe_pkg.sv -----
// Package for the matrix polynomial evaluator core.
// Holds opcodes, register indexes, size constants and the Q16.16 constant one.
// No dependencies.
package mpe_pkg;

	localparam int MAX_SIZE_DEF   = 8;
	localparam int MAX_DEGREE_DEF = 15;
	localparam int DATA_W         = 32;
	localparam int CFG_W          = 4;
	localparam int CFG_IDX_W      = 1;

	typedef enum logic [1:0] {
		OP_LOAD_A    = 2'd0,
		OP_LOAD_COEF = 2'd1,
		OP_COMPUTE   = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 1'd1;

	localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

endpackage

// ----- rtl/core/mpe_mac.sv -----
// Registered multiply unit for the evaluator core (Q16.16 or integer low word).
// The product is registered, then the output word is selected; depends on mpe_pkg.
module mpe_mac
	import mpe_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic              fixed_mode,  // 1: Q16.16 floor product, 0: integer low word
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic [DATA_W-1:0] prod
);
	logic signed [2*DATA_W-1:0] full_s1;
	logic                       fixed_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			full_s1  <= $signed(a) * $signed(b);
			fixed_s1 <= fixed_mode;
		end
	end

	// floor shift of a two's complement product is an arithmetic bit-select
	assign prod = fixed_s1 ? full_s1[DATA_W+15:16] : full_s1[DATA_W-1:0];
endmodule

// ----- rtl/core/matrix_polynomial_evaluator_core.sv -----
// Matrix polynomial evaluator core: P(A) = c0*I + ... + cd*A^d; Q16.16 A, integer c.
// Loads (matrix element, coefficient) are accepted one per cycle while idle, back to back.
// A compute transaction initialises power and sum, then for each power forms the
// product elements and updates the sum, and finally emits the result elements.
// Each result is read from RAM, then moved into the single output register when it is free.
// arst_n clears control and configuration; RAM contents stay undefined.
module matrix_polynomial_evaluator_core
	import mpe_pkg::*;
#(
	parameter int MAX_SIZE   = MAX_SIZE_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// op[1:0], row[4:2], col[7:5], coef_index[11:8], value[43:12], zero pad
	input  logic [47:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_row[2:0], out_col[5:3], out_value[37:6], zero pad
	output logic [39:0]          m_axis_tdata,
	output logic                 m_axis_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam int CELLS = 8 * 8;          // address is row*8+col (3-bit fields)
	localparam int AW    = $clog2(CELLS);
	localparam int CD    = 16;             // coef_index and degree are 4 bits wide
	localparam int CW    = $clog2(CD);

	// input fields
	logic [1:0]        in_op;
	logic [2:0]        in_row, in_col;
	logic [3:0]        in_ci;
	logic [DATA_W-1:0] in_val;
	assign in_op  = s_axis_tdata[1:0];
	assign in_row = s_axis_tdata[4:2];
	assign in_col = s_axis_tdata[7:5];
	assign in_ci  = s_axis_tdata[11:8];
	assign in_val = s_axis_tdata[43:12];

	// configuration
	logic [3:0] size_q, degree_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= 4'd1;
			degree_q <= 4'd0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MATRIX_SIZE) size_q   <= cfg_data;
			if (cfg_index == REG_POLY_DEGREE) degree_q <= cfg_data;
		end
	end

	// memories: A, coefficients, power (ping-pong pair), sum
	logic [DATA_W-1:0] a_mem   [CELLS];
	logic [DATA_W-1:0] c_mem   [CD];
	logic [DATA_W-1:0] p_mem   [2*CELLS];
	logic [DATA_W-1:0] s_mem   [CELLS];
	logic [DATA_W-1:0] a_rd_q, p_rd_q, s_rd_q, c_rd_q;

	typedef enum logic [2:0] {IDLE, INIT, MUL, MULW, SUMR, SUMW, EMIT} state_t;
	state_t state_q;

	logic [2:0]  n_m1_q;           // clamped size minus one
	logic [3:0]  d_q, pw_q;
	logic        pp_q;             // which power bank holds current power
	logic [2:0]  i_q, j_q, k_q;
	logic [1:0]  ph_q;             // pipeline phase within an element
	logic [DATA_W-1:0] acc_q;
	logic        mac_fixed, mac_en;
	logic [DATA_W-1:0] mac_a, mac_b, mac_p;

	mpe_mac u_mac (
		.clk(clk), .en(mac_en), .fixed_mode(mac_fixed),
		.a(mac_a), .b(mac_b), .prod(mac_p)
	);

	logic [AW-1:0] ij_addr;
	assign ij_addr = {i_q, j_q};

	logic in_acc;
	assign s_axis_tready = (state_q == IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// RAM writes and reads (clocked)
	logic             a_we, s_we, p_we, c_we;
	logic [AW-1:0]    a_ra, s_wa, s_ra;
	logic [AW:0]      p_wa, p_ra;
	logic [DATA_W-1:0] s_wd, p_wd;
	logic [CW-1:0]    c_ra;

	assign a_we = in_acc && (in_op == OP_LOAD_A) && (32'(in_row) < MAX_SIZE)
		&& (32'(in_col) < MAX_SIZE);
	assign c_we = in_acc && (in_op == OP_LOAD_COEF) && (32'(in_ci) <= MAX_DEGREE);

	always_ff @(posedge clk) begin
		if (a_we) a_mem[{in_row, in_col}] <= in_val;
		if (c_we) c_mem[in_ci[CW-1:0]] <= in_val;
		if (p_we) p_mem[p_wa] <= p_wd;
		if (s_we) s_mem[s_wa] <= s_wd;
		a_rd_q <= a_mem[a_ra];
		p_rd_q <= p_mem[p_ra];
		s_rd_q <= s_mem[s_ra];
		c_rd_q <= c_mem[c_ra];
	end

	// main sequencer
	// INIT: power=I, sum=I*c0 (the c0 read is registered, so phase 0 waits)
	// MUL : stream k over row i of A and column j of power; read and MAC pipeline 2 deep
	// SUMR/SUMW: sum += next*c[pw], one element at a time: SUMR reads, SUMW multiplies, then writes
	logic last_k;
	assign last_k = (k_q == n_m1_q);

	always_comb begin
		a_ra      = {i_q, k_q};
		p_ra      = {pp_q, k_q, j_q};
		s_ra      = ij_addr;
		c_ra      = (state_q == INIT) ? '0 : pw_q[CW-1:0];
		mac_a     = a_rd_q;
		mac_b     = p_rd_q;
		mac_fixed = 1'b1;
		mac_en    = 1'b0;
		p_we      = 1'b0;
		p_wa      = {~pp_q, ij_addr};
		p_wd      = acc_q + mac_p;
		s_we      = 1'b0;
		s_wa      = ij_addr;
		s_wd      = s_rd_q + mac_p;
		unique case (state_q)
			INIT: begin
				p_we  = (ph_q == 2'd1);
				p_wa  = {pp_q, ij_addr};
				p_wd  = (i_q == j_q) ? ONE_Q16 : '0;
				mac_a = (i_q == j_q) ? ONE_Q16 : '0;
				mac_b = c_rd_q;
				mac_fixed = 1'b0;
				mac_en = (ph_q == 2'd1);
				s_we  = (ph_q == 2'd2);
				s_wd  = mac_p;
			end
			MUL: begin
				mac_en = 1'b1;
			end
			MULW: begin
				mac_en = 1'b1;
				p_we   = (ph_q == 2'd1);
			end
			SUMR: begin
				p_ra   = {pp_q, ij_addr};
			end
			SUMW: begin
				mac_a  = p_rd_q;
				mac_b  = c_rd_q;
				mac_fixed = 1'b0;
				mac_en = (ph_q == 2'd0);
				s_we   = (ph_q == 2'd1);
			end
			default: ;
		endcase
	end

	// output register
	logic        ov_q, ol_q;
	logic [2:0]  orow_q, ocol_q;
	logic [DATA_W-1:0] oval_q;
	logic        emit_rd_q;  // read of s_mem in flight
	logic [2:0]  ei_q, ej_q;
	logic        e_last_q;
	logic        emit_go;    // element already read moves into the output slot

	assign emit_go = (state_q == EMIT) && emit_rd_q && (!ov_q || m_axis_tready);

	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast  = ol_q;
	assign m_axis_tdata  = {2'b00, oval_q, ocol_q, orow_q};

	logic n_last_ij;
	assign n_last_ij = (i_q == n_m1_q) && (j_q == n_m1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ov_q <= 1'b0; ol_q <= 1'b0;
			emit_rd_q <= 1'b0;
			pp_q <= 1'b0;
			i_q <= '0; j_q <= '0; k_q <= '0; ph_q <= '0;
			n_m1_q <= '0; d_q <= '0; pw_q <= '0;
			acc_q <= '0; orow_q <= '0; ocol_q <= '0; oval_q <= '0;
			ei_q <= '0; ej_q <= '0; e_last_q <= 1'b0;
		end else begin
			if (emit_go) ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_acc && in_op == OP_COMPUTE) begin
						if (size_q == 4'd0) n_m1_q <= '0;
						else if (32'(size_q) > MAX_SIZE) n_m1_q <= 3'(MAX_SIZE - 1);
						else n_m1_q <= 3'(size_q - 4'd1);
						d_q <= (32'(degree_q) > MAX_DEGREE) ? 4'(MAX_DEGREE) : degree_q;
						i_q <= '0; j_q <= '0; k_q <= '0; ph_q <= '0;
						pw_q <= 4'd1; pp_q <= 1'b0;
						state_q <= INIT;
					end
				end
				INIT: begin
					if (ph_q == 2'd2) begin
						if (n_last_ij) begin
							i_q <= '0; j_q <= '0;
							ph_q <= '0;
							state_q <= (pw_q <= d_q) ? MUL : EMIT;
							emit_rd_q <= 1'b0;
						end else begin
							ph_q <= 2'd1;
							if (j_q == n_m1_q) begin
								j_q <= '0; i_q <= i_q + 3'd1;
							end else j_q <= j_q + 3'd1;
						end
					end else ph_q <= ph_q + 2'd1;
				end
				MUL: begin
					// step k issues reads; the read data are registered, then the product
					if (k_q == 3'd1 || (n_m1_q == '0)) acc_q <= '0;
					if (k_q >= 3'd2) acc_q <= acc_q + mac_p;
					if (last_k) begin
						state_q <= MULW; ph_q <= '0;
					end else k_q <= k_q + 3'd1;
				end
				MULW: begin
					// drain: ph0 adds penultimate product, ph1 writes final sum
					if (ph_q == 2'd0) begin
						if (n_m1_q != '0) acc_q <= acc_q + mac_p;
						ph_q <= 2'd1;
					end else begin
						k_q <= '0;
						if (n_last_ij) begin
							i_q <= '0; j_q <= '0; ph_q <= '0;
							pp_q <= ~pp_q;
							state_q <= SUMR;
						end else begin
							state_q <= MUL;
							if (j_q == n_m1_q) begin
								j_q <= '0; i_q <= i_q + 3'd1;
							end else j_q <= j_q + 3'd1;
						end
					end
				end
				SUMR: begin
					state_q <= SUMW; ph_q <= '0;
				end
				SUMW: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else if (n_last_ij) begin
						i_q <= '0; j_q <= '0;
						if (pw_q == d_q) state_q <= EMIT;
						else begin
							pw_q <= pw_q + 4'd1;
							state_q <= MUL;
						end
					end else begin
						state_q <= SUMR;
						if (j_q == n_m1_q) begin
							j_q <= '0; i_q <= i_q + 3'd1;
						end else j_q <= j_q + 3'd1;
					end
				end
				EMIT: begin
					// one read in flight; present when output slot is free
					if (!emit_rd_q) begin
						emit_rd_q <= 1'b1;
						ei_q <= i_q; ej_q <= j_q; e_last_q <= n_last_ij;
					end else if (emit_go) begin
						orow_q <= ei_q; ocol_q <= ej_q;
						oval_q <= s_rd_q; ol_q <= e_last_q;
						emit_rd_q <= 1'b0;
						if (e_last_q) state_q <= IDLE;
						else if (j_q == n_m1_q) begin
							j_q <= '0; i_q <= i_q + 3'd1;
						end else j_q <= j_q + 3'd1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
